// ===== rtl/lbp_pkg.sv =====
// Package for the LSB-first bit packer: store geometry, operation codes,
// controller states and the structs passed between modules.
// Depends on nothing; every other file but lbp_bank imports it.
package lbp_pkg;

  // Store geometry
  localparam int STORE_BYTES = 64;
  localparam int BYTE_W      = 8;
  localparam int STORE_BITS  = STORE_BYTES * BYTE_W;
  localparam int CUR_W       = 10;
  localparam int CNT_W       = 6;
  localparam int WORD_W      = 32;
  localparam int OFF_W       = $clog2(WORD_W);
  localparam int NUM_WORDS   = STORE_BITS / WORD_W;
  localparam int WIX_W       = $clog2(NUM_WORDS);
  localparam int BANK_DEPTH  = NUM_WORDS / 2;
  localparam int BA_W        = $clog2(BANK_DEPTH);

  // Word packing on the ports
  localparam int OP_W      = 2;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_PUT   = 2'd2,
    OP_GET   = 2'd3
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // One captured input word
  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  bit_count;
    logic [WORD_W-1:0] write_value;
    logic [CUR_W-1:0]  new_position;
  } item_t;

  // Outcome of one operation, worked out from the fetched window
  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              fault;
    logic [CUR_W-1:0]  cursor_nxt;
    logic              wr;
    logic              clear;
    logic [WORD_W-1:0] lo_new;
    logic [WORD_W-1:0] hi_new;
  } exec_t;

  // Controller strobes
  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic commit;
  } ctrl_t;

endpackage

// ===== rtl/lsb_first_bit_packer_core.sv =====
// Top level of the LSB-first bit packer: two 32-bit RAM banks, word valid
// bits, the bit cursor and the output register.
// Depends on lbp_pkg, lbp_bank, lbp_ctrl and lbp_exec.
//
//   channel | dir | tdata (low bit up)                       | tuser
//   --------+-----+------------------------------------------+------------
//   in_     | in  | bit_count, write_value, new_position     | operation
//   out_    | out | read_value, cursor_after, zero padding   | fault
//
// On acceptance the two store words under the cursor are read from the even
// and odd banks; once the output register is free, the merged window is
// written back and the output register loaded. A new word is accepted
// while a result waits; the write-back stage holds while the output register
// is full and not taken. Clear drops all word valid bits at once, so no
// clearing pass is needed; reset clears the cursor, valid bits and control state.
module lsb_first_bit_packer_core
  import lbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // bit_count, write_value, new_position
  input  logic [OP_W-1:0]       in_tuser,  // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // read_value, cursor_after, padding
  output logic                  out_tuser  // fault
);

  ctrl_t             ctl;
  item_t             item_r;
  exec_t             res;
  logic [CUR_W-1:0]  cursor_r;
  logic [NUM_WORDS-1:0] valid_r, valid_nxt;
  logic              ev_ok_r, od_ok_r;
  logic [WIX_W-1:0]  w_ix, w_ix_p1;
  logic [BA_W-1:0]   ev_addr, od_addr;
  logic [WORD_W-1:0] ev_rd, od_rd, ev_word, od_word, lo_word, hi_word;
  logic [WORD_W-1:0] ev_wdata, od_wdata;
  logic              wr_en;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_rval_r;
  logic              out_fault_r;
  logic [CUR_W-1:0]  out_cursor_r;
  logic              out_free;

  // Sequencer
  assign out_free = !out_valid_r || out_tready;

  lbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  assign in_tready = ctl.in_ready;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      item_r.op           <= op_t'(in_tuser);
      item_r.bit_count    <= in_tdata[CNT_W-1:0];
      item_r.write_value  <= in_tdata[CNT_W +: WORD_W];
      item_r.new_position <= in_tdata[CNT_W+WORD_W +: CUR_W];
    end
  end

  // Bank addressing: word w and w+1 always sit in different banks
  always_comb begin
    w_ix    = cursor_r[OFF_W +: WIX_W];
    w_ix_p1 = w_ix + WIX_W'(1);
    ev_addr = w_ix[0] ? w_ix_p1[WIX_W-1:1] : w_ix[WIX_W-1:1];
    od_addr = w_ix[WIX_W-1:1];
  end

  lbp_bank #(.DEPTH(BANK_DEPTH), .WIDTH(WORD_W)) u_bank_ev (
    .clk     (clk),
    .rd_en   (ctl.rd_en),
    .rd_addr (ev_addr),
    .rd_data (ev_rd),
    .wr_en   (wr_en),
    .wr_addr (ev_addr),
    .wr_data (ev_wdata)
  );

  lbp_bank #(.DEPTH(BANK_DEPTH), .WIDTH(WORD_W)) u_bank_od (
    .clk     (clk),
    .rd_en   (ctl.rd_en),
    .rd_addr (od_addr),
    .rd_data (od_rd),
    .wr_en   (wr_en),
    .wr_addr (od_addr),
    .wr_data (od_wdata)
  );

  // Valid bits are sampled alongside the read so an unwritten word reads zero
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      ev_ok_r <= valid_r[{ev_addr, 1'b0}];
      od_ok_r <= valid_r[{od_addr, 1'b1}];
    end
  end

  always_comb begin
    ev_word = ev_ok_r ? ev_rd : '0;
    od_word = od_ok_r ? od_rd : '0;
    lo_word = w_ix[0] ? od_word : ev_word;
    hi_word = w_ix[0] ? ev_word : od_word;
  end

  // Modify
  lbp_exec u_exec (
    .item    (item_r),
    .cursor  (cursor_r),
    .lo_word (lo_word),
    .hi_word (hi_word),
    .res     (res)
  );

  // Write back
  always_comb begin
    wr_en    = ctl.commit && res.wr;
    ev_wdata = w_ix[0] ? res.hi_new : res.lo_new;
    od_wdata = w_ix[0] ? res.lo_new : res.hi_new;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.commit && res.clear) begin
      valid_nxt = '0;
    end else if (wr_en) begin
      valid_nxt[{ev_addr, 1'b0}] = 1'b1;
      valid_nxt[{od_addr, 1'b1}] = 1'b1;
    end
  end

  // Cursor and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      valid_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (ctl.commit) begin
        cursor_r <= res.cursor_nxt;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_rval_r   <= res.read_value;
      out_fault_r  <= res.fault;
      out_cursor_r <= res.cursor_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-WORD_W-CUR_W){1'b0}}, out_cursor_r, out_rval_r};
  assign out_tuser  = out_fault_r;

endmodule

// ===== rtl/lbp_bank.sv =====
// Generic single-port-write, single-port-read synchronous RAM bank.
// Read data is registered and only updates when a read is issued.
// Depends on nothing.
module lbp_bank #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/lbp_ctrl.sv =====
// Two-state sequencer: fetch on acceptance, then modify and write back once
// the output register is free. Depends on lbp_pkg.
module lbp_ctrl
  import lbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  out_free,
  output ctrl_t ctl
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Strobes
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        ctl.in_ready = rst_n;
        ctl.rd_en    = rst_n & in_valid;
      end
      S_EXEC: begin
        ctl.commit = out_free;
      end
      default: ctl = '0;
    endcase
  end

endmodule

// ===== rtl/lbp_exec.sv =====
// Modify stage: clamps the bit count to the room left, merges put bits into
// the fetched 64-bit window or extracts get bits from it, and works out the
// new cursor. Depends on lbp_pkg.
module lbp_exec
  import lbp_pkg::*;
(
  input  item_t             item,
  input  logic [CUR_W-1:0]  cursor,
  input  logic [WORD_W-1:0] lo_word,
  input  logic [WORD_W-1:0] hi_word,
  output exec_t             res
);

  logic [CUR_W-1:0]    avail;
  logic                is_move;
  logic                over;
  logic [CNT_W-1:0]    n_bits;
  logic [WORD_W-1:0]   mask;
  logic [OFF_W-1:0]    off;
  logic [2*WORD_W-1:0] window;
  logic [2*WORD_W-1:0] ins;
  logic [2*WORD_W-1:0] merged;
  logic [2*WORD_W-1:0] fetched;

  // Room left before the end of the store, and the clamped count
  always_comb begin
    avail   = CUR_W'(STORE_BITS) - cursor;
    is_move = (item.op == OP_PUT) || (item.op == OP_GET);
    over    = is_move && (CUR_W'(item.bit_count) > avail);
    n_bits  = over ? avail[CNT_W-1:0] : item.bit_count;
    if (n_bits >= CNT_W'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = (WORD_W'(1) << n_bits[OFF_W-1:0]) - WORD_W'(1);
    end
  end

  // Window merge and extraction
  always_comb begin
    off     = cursor[OFF_W-1:0];
    window  = {hi_word, lo_word};
    ins     = {{WORD_W{1'b0}}, item.write_value & mask} << off;
    merged  = window | ins;
    fetched = window >> off;
  end

  // Result per operation
  always_comb begin
    res            = '0;
    res.fault      = over;
    res.lo_new     = merged[WORD_W-1:0];
    res.hi_new     = merged[2*WORD_W-1:WORD_W];
    res.cursor_nxt = cursor;
    case (item.op)
      OP_CLEAR: begin
        res.clear = 1'b1;
      end
      OP_SET: begin
        if (item.new_position > CUR_W'(STORE_BITS)) begin
          res.cursor_nxt = CUR_W'(STORE_BITS);
        end else begin
          res.cursor_nxt = item.new_position;
        end
      end
      OP_PUT: begin
        res.cursor_nxt = cursor + CUR_W'(n_bits);
        res.wr         = (n_bits != '0);
      end
      OP_GET: begin
        res.cursor_nxt = cursor + CUR_W'(n_bits);
        res.read_value = fetched[WORD_W-1:0] & mask;
      end
      default: res.cursor_nxt = cursor;
    endcase
  end

endmodule

// ===== rtl/lbp_checker.sv =====
// Port-level checker for the bit packer, bound to the top level.
// Depends on lbp_pkg and lsb_first_bit_packer_core.
module lbp_checker
  import lbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // Input words are never accepted back to back
  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A fault only happens once the cursor has reached the end of the store
  a_fault_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[WORD_W +: CUR_W] == CUR_W'(STORE_BITS))
    else $error("fault reported with cursor short of store end");

  // The cursor never passes the end of the store
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[WORD_W +: CUR_W] <= CUR_W'(STORE_BITS))
    else $error("cursor beyond store end");

endmodule

bind lsb_first_bit_packer_core lbp_checker u_lbp_checker (.*);

// ===== sim/lsb_first_bit_packer_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LSB-first bit packer: a directed table, then random
// clear, set, put and get words checked against a bit-level predictor of store and cursor.
// Depends on lbp_pkg and lsb_first_bit_packer_core.
module lsb_first_bit_packer_core_test;
  import lbp_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] read_value;
    logic              fault;
    logic [CUR_W-1:0]  cursor;
  } bit_result_t;

  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  bit_count;
    logic [WORD_W-1:0] write_value;
    logic [CUR_W-1:0]  new_position;
    logic              typed;
    bit_result_t       want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Predicted store contents and cursor.
  logic [BYTE_W-1:0] store_bytes [STORE_BYTES];
  int                cursor_bits;

  bit_result_t pending_results [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  bit          no_idle = 1'b0;

  lsb_first_bit_packer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Bit-serial model of one operation: updates the store and cursor, returns the result.
  function automatic bit_result_t apply_bit_op(op_t op, logic [CNT_W-1:0] cnt,
                                               logic [WORD_W-1:0] wval,
                                               logic [CUR_W-1:0] npos);
    bit_result_t r;
    int k;
    bit stopped;
    r = '0;
    stopped = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (k = 0; k < STORE_BYTES; k++) store_bytes[k] = '0;
      end
      OP_SET: begin
        cursor_bits = (int'(npos) > STORE_BITS) ? STORE_BITS : int'(npos);
      end
      default: begin
        for (k = 0; k < int'(cnt); k++) begin
          if (!stopped) begin
            if (cursor_bits >= STORE_BITS) begin
              r.fault = 1'b1;
              stopped = 1'b1;
            end else begin
              if (k < WORD_W) begin
                if (op == OP_PUT) begin
                  if (wval[k]) store_bytes[cursor_bits / BYTE_W][cursor_bits % BYTE_W] = 1'b1;
                end else begin
                  r.read_value[k] = store_bytes[cursor_bits / BYTE_W][cursor_bits % BYTE_W];
                end
              end
              cursor_bits++;
            end
          end
        end
      end
    endcase
    r.cursor = cursor_bits[CUR_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input op_t op, input int cnt, input logic [WORD_W-1:0] wval,
                         input int npos, input bit typed, input logic [WORD_W-1:0] rval,
                         input bit fault, input int cur);
    stim_row_t row;
    row.op           = op;
    row.bit_count    = cnt[CNT_W-1:0];
    row.write_value  = wval;
    row.new_position = npos[CUR_W-1:0];
    row.typed        = typed;
    row.want         = '{read_value: rval, fault: fault, cursor: cur[CUR_W-1:0]};
    directed_rows.push_back(row);
  endtask

  // Offers one word, with random idle cycles ahead of it, and records its expected result
  // once accepted. The typed expectation, where given, replaces the predicted one.
  task automatic send_word(input op_t op, input logic [CNT_W-1:0] cnt,
                           input logic [WORD_W-1:0] wval, input logic [CUR_W-1:0] npos,
                           input bit typed, input bit_result_t typed_want);
    bit fire;
    bit_result_t predicted;
    while (!no_idle && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {npos, wval, cnt};
    in_tuser  <= op;
    // Inputs only change at the rising edge, so the falling edge sees what the next
    // rising edge will act on.
    do begin
      @(negedge clk);
      fire = in_tready;
      @(posedge clk);
    end while (!fire);
    predicted = apply_bit_op(op, cnt, wval, npos);
    pending_results.push_back(typed ? typed_want : predicted);
    words_sent++;
  endtask

  function automatic int pick_position();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(STORE_BITS, 0);
    if (r < 90) return $urandom_range(STORE_BITS, STORE_BITS - 40);
    return $urandom_range(1023, STORE_BITS + 1);
  endfunction

  function automatic int pick_count();
    if ($urandom_range(99) < 85) return $urandom_range(WORD_W, 0);
    return $urandom_range(63, WORD_W + 1);
  endfunction

  // Receiver back-pressure, switched off during the steady stretch.
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 25);
  end

  // Check each accepted result word against the oldest expectation.
  always @(negedge clk) begin : check_results
    bit_result_t want;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected", out_tdata[WORD_W-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[WORD_W-1:0] !== want.read_value)
          report_mismatch("read_value", out_tdata[WORD_W-1:0], want.read_value);
        if (out_tuser !== want.fault)
          report_mismatch("fault", WORD_W'(out_tuser), WORD_W'(want.fault));
        if (out_tdata[WORD_W+CUR_W-1:WORD_W] !== want.cursor)
          report_mismatch("cursor_after", WORD_W'(out_tdata[WORD_W+CUR_W-1:WORD_W]),
                          WORD_W'(want.cursor));
      end
    end
  end

  // Main sequence: reset, directed table, random traffic, drain and verdict.
  initial begin
    int sel;
    int pos;
    int cnt;
    logic [WORD_W-1:0] val;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_CLEAR;
    for (int i = 0; i < STORE_BYTES; i++) store_bytes[i] = '0;
    cursor_bits = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    //      op        count  write_value    new_pos typed read_value  fault cursor
    add_row(OP_GET,   32,    32'h0,         0,      1,    32'h0,        0,  32);
    add_row(OP_SET,   0,     32'h0,         0,      1,    32'h0,        0,  0);
    add_row(OP_PUT,   32,    32'hffff_ffff, 1023,   1,    32'h0,        0,  32);
    add_row(OP_SET,   63,    32'hffff_ffff, 0,      1,    32'h0,        0,  0);
    add_row(OP_GET,   32,    32'h0,         0,      1,    32'hffff_ffff, 0, 32);
    add_row(OP_SET,   0,     32'h0,         1023,   1,    32'h0,        0,  512);
    add_row(OP_PUT,   5,     32'h1f,        0,      1,    32'h0,        1,  512);
    add_row(OP_GET,   5,     32'h0,         0,      1,    32'h0,        1,  512);
    add_row(OP_PUT,   0,     32'hffff_ffff, 0,      1,    32'h0,        0,  512);
    add_row(OP_GET,   0,     32'h0,         0,      1,    32'h0,        0,  512);
    add_row(OP_SET,   0,     32'h0,         512,    1,    32'h0,        0,  512);
    add_row(OP_SET,   0,     32'h0,         500,    1,    32'h0,        0,  500);
    add_row(OP_PUT,   32,    32'haaaa_aaaa, 0,      0,    32'h0,        0,  0);
    add_row(OP_SET,   0,     32'h0,         500,    1,    32'h0,        0,  500);
    add_row(OP_GET,   32,    32'h0,         0,      0,    32'h0,        0,  0);
    add_row(OP_CLEAR, 63,    32'hffff_ffff, 1023,   1,    32'h0,        0,  512);
    add_row(OP_SET,   0,     32'h0,         511,    1,    32'h0,        0,  511);
    add_row(OP_GET,   1,     32'h0,         0,      1,    32'h0,        0,  512);
    add_row(OP_SET,   0,     32'h0,         0,      1,    32'h0,        0,  0);
    add_row(OP_PUT,   63,    32'h1234_5678, 0,      1,    32'h0,        0,  63);
    add_row(OP_SET,   0,     32'h0,         0,      1,    32'h0,        0,  0);
    add_row(OP_GET,   63,    32'h0,         0,      1,    32'h1234_5678, 0, 63);
    add_row(OP_SET,   0,     32'h0,         29,     1,    32'h0,        0,  29);
    add_row(OP_PUT,   33,    32'h5a5a_c3c3, 0,      0,    32'h0,        0,  0);
    add_row(OP_SET,   0,     32'h0,         29,     1,    32'h0,        0,  29);
    add_row(OP_GET,   40,    32'h0,         0,      0,    32'h0,        0,  0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].bit_count, directed_rows[i].write_value,
                directed_rows[i].new_position, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic: mostly write-then-read-back sequences at random positions, with
    // clears, bare cursor moves and loose puts and gets mixed in.
    while (words_sent < 1800) begin
      no_idle = (words_sent >= 700 && words_sent < 1100);
      sel = $urandom_range(99);
      pos = pick_position();
      cnt = pick_count();
      val = $urandom;
      if (sel < 35) begin
        send_word(OP_SET, CNT_W'($urandom), $urandom, CUR_W'(pos), 1'b0, '0);
        send_word(OP_PUT, CNT_W'(cnt), val, CUR_W'($urandom), 1'b0, '0);
        send_word(OP_SET, CNT_W'($urandom), $urandom, CUR_W'(pos), 1'b0, '0);
        send_word(OP_GET, CNT_W'(cnt), $urandom, CUR_W'($urandom), 1'b0, '0);
      end else if (sel < 38) begin
        send_word(OP_CLEAR, CNT_W'($urandom), $urandom, CUR_W'($urandom), 1'b0, '0);
      end else if (sel < 55) begin
        send_word(OP_SET, CNT_W'($urandom), $urandom, CUR_W'(pos), 1'b0, '0);
      end else begin
        send_word(($urandom_range(1) != 0) ? OP_PUT : OP_GET, CNT_W'(cnt), val,
                  CUR_W'($urandom), 1'b0, '0);
      end
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    // Drain, then keep waiting so that any stray result word can still show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Overall time limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== lsb_first_bit_packer_core.f =====
rtl/lbp_pkg.sv
rtl/lbp_bank.sv
rtl/lbp_ctrl.sv
rtl/lbp_exec.sv
rtl/lsb_first_bit_packer_core.sv
rtl/lbp_checker.sv
sim/lsb_first_bit_packer_core_test.sv
